// File: rtl/point_cloud_transform_colour_map_assert.svh
// Assertion macros shared by the colour map block.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef POINT_CLOUD_TRANSFORM_COLOUR_MAP_ASSERT_SVH
`define POINT_CLOUD_TRANSFORM_COLOUR_MAP_ASSERT_SVH

`ifndef ASSERT_OFF
`define PCM_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define PCM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define PCM_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define PCM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// File: rtl/pcm_pkg.sv
package pcm_pkg;

	// colour store size in bytes
	localparam int unsigned COLOUR_BYTES = 1048576;

	// store split into four byte banks by the two low address bits
	localparam int unsigned BANKS      = 4;
	localparam int unsigned BANK_DEPTH = (COLOUR_BYTES + BANKS - 1) / BANKS;
	localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

	// pixel address: x*bpp + y*stride, +2 for the last byte
	localparam int unsigned ADDR_W = 29;

	localparam int unsigned NUM_STAGES  = 7;
	localparam int unsigned TDATA_IN_W  = 192;
	localparam int unsigned TDATA_OUT_W = 72;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [15:0] pos_t;
	typedef logic [7:0]         byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_BYTES_PER_PIXEL = 3'd2,
		REG_ROW_STRIDE      = 3'd3,
		REG_SCALE_FACTOR    = 3'd4
	} cfg_reg_t;

	localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd640;
	localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd480;
	localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd3;
	localparam logic [14:0] RST_ROW_STRIDE      = 15'd1920;
	localparam logic [15:0] RST_SCALE_FACTOR    = 16'd1000;

	// coefficients in units of 1e-8, rounded half away from zero to Q2.30
	localparam longint Q30  = 64'sd1073741824;
	localparam longint HALF = 64'sd50000000;
	localparam longint DEN  = 64'sd100000000;

	localparam longint R00 = -((64'sd69888007 * Q30 + HALF) / DEN);
	localparam longint R01 = -((64'sd32213748 * Q30 + HALF) / DEN);
	localparam longint R02 =  ((64'sd63858757 * Q30 + HALF) / DEN);
	localparam longint R03 = -((64'sd222900000 * Q30 + HALF) / DEN);
	localparam longint R10 = -((64'sd71520905 * Q30 + HALF) / DEN);
	localparam longint R11 =  ((64'sd32290986 * Q30 + HALF) / DEN);
	localparam longint R12 = -((64'sd61984291 * Q30 + HALF) / DEN);
	localparam longint R13 =  ((64'sd291800000 * Q30 + HALF) / DEN);
	localparam longint R20 = -((64'sd653159 * Q30 + HALF) / DEN);
	localparam longint R21 = -((64'sd88991947 * Q30 + HALF) / DEN);
	localparam longint R22 = -((64'sd45607091 * Q30 + HALF) / DEN);
	localparam longint R23 =  ((64'sd36400000 * Q30 + HALF) / DEN);

	localparam coord_t ROT [3][3] = '{
		'{coord_t'(R00), coord_t'(R01), coord_t'(R02)},
		'{coord_t'(R10), coord_t'(R11), coord_t'(R12)},
		'{coord_t'(R20), coord_t'(R21), coord_t'(R22)}
	};

	// translation aligned to 46 fractional bits
	localparam logic signed [63:0] TRN [3] = '{
		R03 * 64'sd65536, R13 * 64'sd65536, R23 * 64'sd65536
	};

	localparam pos_t POS_MAX = 16'sh7fff;
	localparam pos_t POS_MIN = 16'sh8000;

	// per-stage load enables, occupancy and item kind (1 = point)
	typedef struct packed {
		logic [NUM_STAGES:1] ld;
		logic [NUM_STAGES:1] vld;
		logic [NUM_STAGES:1] pt;
	} pipe_t;

endpackage

// File: rtl/point_cloud_transform_colour_map.sv
// Channel     | Dir | Beat contents (lowest bits first)
// s_axis      | in  | tuser: req_type; tdata: store_addr, store_byte, vert_x..z, tex_u, tex_v
// m_axis      | out | tdata: pos_x, pos_y, pos_z, colour_pair, colour_third
// cfg         | in  | cfg_we, cfg_index, cfg_data: one register write per cycle
//
// One beat per cycle in while s_axis_tready is high; a point's result beat is valid when it reaches stage 7.
// The store is four byte banks with one registered port each, so the three
// pixel bytes are read in the same cycle; a store write uses the same port slot.
// arst_n clears the stage valids and loads the default register values; the
// colour store is not cleared. An empty stage always takes the beat behind it,
// so bubbles close up while m_axis_tready is low.
`include "point_cloud_transform_colour_map_assert.svh"

module point_cloud_transform_colour_map (
	input  logic                               clk,
	input  logic                               arst_n,
	// cfg
	input  logic                               cfg_we,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input beats
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// store_addr[19:0], store_byte[27:20], vert_x[59:28], vert_y[91:60],
	// vert_z[123:92], tex_u[155:124], tex_v[187:156], zero pad
	input  logic [pcm_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
	// req_type: 0 writes a colour byte, 1 processes a point
	input  logic                               s_axis_tuser,
	// result beats
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// pos_x[15:0], pos_y[31:16], pos_z[47:32], colour_pair[63:48], colour_third[71:64]
	output logic [pcm_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

	import pcm_pkg::*;

	// configuration registers
	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic [2:0]  bytes_per_pixel_q;
	logic [14:0] row_stride_q;
	logic [15:0] scale_factor_q;

	// pipeline control
	logic [NUM_STAGES:1] ld;
	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] pt_q;
	pipe_t               pipe;

	// input stage
	logic [19:0] store_addr_s1;
	byte_t       store_byte_s1;
	coord_t      vert_s1 [3];
	coord_t      tex_s1  [2];

	logic [ADDR_W-1:0] addr_s5;
	pos_t              pos_s7 [3];
	logic [15:0]       colour_pair_s7;
	byte_t             colour_third_s7;

	// hold register writes to their own field widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= RST_IMAGE_WIDTH;
			image_height_q    <= RST_IMAGE_HEIGHT;
			bytes_per_pixel_q <= RST_BYTES_PER_PIXEL;
			row_stride_q      <= RST_ROW_STRIDE;
			scale_factor_q    <= RST_SCALE_FACTOR;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:     image_width_q     <= cfg_data[12:0];
				REG_IMAGE_HEIGHT:    image_height_q    <= cfg_data[12:0];
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[2:0];
				REG_ROW_STRIDE:      row_stride_q      <= cfg_data[14:0];
				REG_SCALE_FACTOR:    scale_factor_q    <= cfg_data;
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it loads too.
	always_comb begin
		ld[NUM_STAGES] = !vld_q[NUM_STAGES] || m_axis_tready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign s_axis_tready = ld[1];

	// Advance valids; a write beat leaves once its store slot has gone by.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k < NUM_STAGES; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (ld[NUM_STAGES]) begin
				vld_q[NUM_STAGES] <= vld_q[NUM_STAGES-1] && pt_q[NUM_STAGES-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			pt_q[1] <= s_axis_tuser;
		end
		for (int k = 2; k <= NUM_STAGES; k++) begin
			if (ld[k]) begin
				pt_q[k] <= pt_q[k-1];
			end
		end
	end

	// capture the beat fields
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			store_addr_s1 <= s_axis_tdata[19:0];
			store_byte_s1 <= s_axis_tdata[27:20];
			vert_s1[0]    <= s_axis_tdata[59:28];
			vert_s1[1]    <= s_axis_tdata[91:60];
			vert_s1[2]    <= s_axis_tdata[123:92];
			tex_s1[0]     <= s_axis_tdata[155:124];
			tex_s1[1]     <= s_axis_tdata[187:156];
		end
	end

	assign pipe = '{ld: ld, vld: vld_q, pt: pt_q};

	pcm_xform u_xform (
		.clk         (clk),
		.pipe        (pipe),
		.scale_factor(scale_factor_q),
		.vert_s1     (vert_s1),
		.pos_s7      (pos_s7)
	);

	pcm_texaddr u_texaddr (
		.clk            (clk),
		.pipe           (pipe),
		.image_width    (image_width_q),
		.image_height   (image_height_q),
		.bytes_per_pixel(bytes_per_pixel_q),
		.row_stride     (row_stride_q),
		.tex_s1         (tex_s1),
		.addr_s5        (addr_s5)
	);

	pcm_store u_store (
		.clk            (clk),
		.pipe           (pipe),
		.store_addr_s1  (store_addr_s1),
		.store_byte_s1  (store_byte_s1),
		.addr_s5        (addr_s5),
		.colour_pair_s7 (colour_pair_s7),
		.colour_third_s7(colour_third_s7)
	);

	assign m_axis_tvalid = vld_q[NUM_STAGES];
	assign m_axis_tdata  = {colour_third_s7, colour_pair_s7, pos_s7[2], pos_s7[1], pos_s7[0]};

	`PCM_ASSERT_IMP(a_ready_when_first_free, clk, arst_n, !vld_q[1], s_axis_tready)
	`PCM_ASSERT_IMP(a_taken_drains_all, clk, arst_n, m_axis_tready, ld == '1)
	`PCM_ASSERT_NEXT(a_write_gives_no_beat, clk, arst_n,
		ld[NUM_STAGES] && vld_q[NUM_STAGES-1] && !pt_q[NUM_STAGES-1], !m_axis_tvalid)
	`PCM_ASSERT_NEXT(a_point_gives_beat, clk, arst_n,
		ld[NUM_STAGES] && vld_q[NUM_STAGES-1] && pt_q[NUM_STAGES-1], m_axis_tvalid)

endmodule

// File: rtl/pcm_ram.sv
module pcm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/pcm_xform.sv
module pcm_xform (
	input  logic           clk,
	input  pcm_pkg::pipe_t pipe,
	input  logic [15:0]    scale_factor,
	input  pcm_pkg::coord_t vert_s1 [3],
	output pcm_pkg::pos_t  pos_s7 [3]
);

	import pcm_pkg::*;

	logic signed [63:0] prod_s2 [3][3];
	logic signed [63:0] psum_s3 [3];
	logic signed [63:0] tsum_s3 [3];
	logic signed [63:0] acc_s4  [3];
	logic [63:0]        mag_s5  [3];
	logic               neg_s5  [3];
	logic [47:0]        ph_s6   [3];
	logic [47:0]        pl_s6   [3];
	logic               neg_s6  [3];

	logic [48:0] qsum [3];
	logic [34:0] q    [3];

	// rotation products
	always_ff @(posedge clk) begin
		if (pipe.ld[2]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= vert_s1[c] * ROT[r][c];
				end
			end
		end
	end

	// sum the row in two levels
	always_ff @(posedge clk) begin
		if (pipe.ld[3]) begin
			for (int r = 0; r < 3; r++) begin
				psum_s3[r] <= prod_s2[r][0] + prod_s2[r][1];
				tsum_s3[r] <= prod_s2[r][2] + TRN[r];
			end
		end
		if (pipe.ld[4]) begin
			for (int r = 0; r < 3; r++) begin
				acc_s4[r] <= psum_s3[r] + tsum_s3[r];
			end
		end
	end

	// magnitude, then scale by halves of the magnitude
	always_ff @(posedge clk) begin
		if (pipe.ld[5]) begin
			for (int r = 0; r < 3; r++) begin
				neg_s5[r] <= acc_s4[r][63];
				mag_s5[r] <= acc_s4[r][63] ? 64'(-acc_s4[r]) : 64'(acc_s4[r]);
			end
		end
		if (pipe.ld[6]) begin
			for (int r = 0; r < 3; r++) begin
				neg_s6[r] <= neg_s5[r];
				ph_s6[r]  <= mag_s5[r][63:32] * scale_factor;
				pl_s6[r]  <= mag_s5[r][31:0] * scale_factor;
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			qsum[r] = {1'b0, ph_s6[r]} + 49'(pl_s6[r][47:32]);
			q[r]    = qsum[r][48:14];
		end
	end

	// truncate toward zero and saturate
	always_ff @(posedge clk) begin
		if (pipe.ld[7]) begin
			for (int r = 0; r < 3; r++) begin
				if (neg_s6[r]) begin
					pos_s7[r] <= (q[r] > 35'd32768) ? POS_MIN : 16'(35'd0 - q[r]);
				end else begin
					pos_s7[r] <= (q[r] > 35'd32767) ? POS_MAX : 16'(q[r]);
				end
			end
		end
	end

endmodule

// File: rtl/pcm_texaddr.sv
module pcm_texaddr (
	input  logic               clk,
	input  pcm_pkg::pipe_t     pipe,
	input  logic [12:0]        image_width,
	input  logic [12:0]        image_height,
	input  logic [2:0]         bytes_per_pixel,
	input  logic [14:0]        row_stride,
	input  pcm_pkg::coord_t    tex_s1 [2],
	output logic [pcm_pkg::ADDR_W-1:0] addr_s5
);

	import pcm_pkg::*;

	logic [12:0]        size [2];
	logic signed [45:0] tprod_s2 [2];
	logic [12:0]        coord_s3 [2];
	logic [15:0]        ax_s4;
	logic [27:0]        ay_s4;

	logic signed [45:0] p    [2];
	logic [29:0]        idx  [2];
	logic [12:0]        last [2];
	logic [12:0]        coord_d [2];

	assign size[0] = image_width;
	assign size[1] = image_height;

	always_ff @(posedge clk) begin
		if (pipe.ld[2]) begin
			for (int i = 0; i < 2; i++) begin
				tprod_s2[i] <= tex_s1[i] * $signed({1'b0, size[i]});
			end
		end
	end

	// round to the nearest pixel and clamp into the image
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			p[i]    = tprod_s2[i] + 46'sd32768;
			idx[i]  = p[i][45:16];
			last[i] = size[i] - 13'd1;
			if (size[i] == 13'd0 || p[i][45]) begin
				coord_d[i] = 13'd0;
			end else if (idx[i] > {17'd0, last[i]}) begin
				coord_d[i] = last[i];
			end else begin
				coord_d[i] = idx[i][12:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.ld[3]) begin
			coord_s3 <= coord_d;
		end
		if (pipe.ld[4]) begin
			ax_s4 <= coord_s3[0] * bytes_per_pixel;
			ay_s4 <= coord_s3[1] * row_stride;
		end
		if (pipe.ld[5]) begin
			addr_s5 <= ADDR_W'(ax_s4) + ADDR_W'(ay_s4);
		end
	end

endmodule

// File: rtl/pcm_store.sv
module pcm_store (
	input  logic                       clk,
	input  pcm_pkg::pipe_t             pipe,
	input  logic [19:0]                store_addr_s1,
	input  pcm_pkg::byte_t             store_byte_s1,
	input  logic [pcm_pkg::ADDR_W-1:0] addr_s5,
	output logic [15:0]                colour_pair_s7,
	output pcm_pkg::byte_t             colour_third_s7
);

	import pcm_pkg::*;

	logic [19:0] wr_addr_s2, wr_addr_s3, wr_addr_s4, wr_addr_s5;
	byte_t       wr_byte_s2, wr_byte_s3, wr_byte_s4, wr_byte_s5, wr_byte_s6;

	logic [BANK_AW-1:0] row_s6 [BANKS];
	logic [BANKS-1:0]   we_s6;
	logic [BANKS-1:0]   hit_s6;
	logic [1:0]         sel_s6;
	logic [BANKS-1:0]   hit_s7;
	logic [1:0]         sel_s7;

	logic [1:0]         ofs    [BANKS];
	logic [ADDR_W-1:0]  ba     [BANKS];
	logic [BANKS-1:0]   rd_hit;
	logic [BANKS-1:0]   wr_hit;
	logic [ADDR_W-1:0]  wa;
	logic [BANK_AW-1:0] row_d  [BANKS];
	byte_t              rdata  [BANKS];
	logic [1:0]         bsel   [3];
	byte_t              pix    [3];

	// carry the write beat alongside the point
	always_ff @(posedge clk) begin
		if (pipe.ld[2]) begin
			wr_addr_s2 <= store_addr_s1;
			wr_byte_s2 <= store_byte_s1;
		end
		if (pipe.ld[3]) begin
			wr_addr_s3 <= wr_addr_s2;
			wr_byte_s3 <= wr_byte_s2;
		end
		if (pipe.ld[4]) begin
			wr_addr_s4 <= wr_addr_s3;
			wr_byte_s4 <= wr_byte_s3;
		end
		if (pipe.ld[5]) begin
			wr_addr_s5 <= wr_addr_s4;
			wr_byte_s5 <= wr_byte_s4;
		end
	end

	// route the three pixel bytes, or the write byte, to their banks
	always_comb begin
		wa = ADDR_W'(wr_addr_s5);
		for (int b = 0; b < BANKS; b++) begin
			ofs[b]    = 2'(b) - addr_s5[1:0];
			ba[b]     = addr_s5 + ADDR_W'(ofs[b]);
			rd_hit[b] = (ofs[b] != 2'd3) && (ba[b] < ADDR_W'(COLOUR_BYTES));
			wr_hit[b] = (wa[1:0] == 2'(b)) && (wa < ADDR_W'(COLOUR_BYTES));
			row_d[b]  = pipe.pt[5] ? ba[b][BANK_AW+1:2] : wa[BANK_AW+1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.ld[6]) begin
			row_s6     <= row_d;
			we_s6      <= pipe.pt[5] ? '0 : wr_hit;
			hit_s6     <= rd_hit;
			sel_s6     <= addr_s5[1:0];
			wr_byte_s6 <= wr_byte_s5;
		end
		if (pipe.ld[7]) begin
			hit_s7 <= hit_s6;
			sel_s7 <= sel_s6;
		end
	end

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		pcm_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.en   (pipe.ld[7]),
			.we   (we_s6[b] && pipe.vld[6]),
			.addr (row_s6[b]),
			.wdata(wr_byte_s6),
			.rdata(rdata[b])
		);
	end

	// bytes beyond the store read as zero
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bsel[k] = sel_s7 + 2'(k);
			pix[k]  = hit_s7[bsel[k]] ? rdata[bsel[k]] : 8'd0;
		end
	end

	assign colour_pair_s7  = {pix[1], pix[0]};
	assign colour_third_s7 = pix[2];

endmodule
